### hw/rtl/owrs_pkg.sv
// Shared types and constants for the 1-Wire search-ROM decision engine.
// Depends on nothing; every other file in this block depends on it.
package owrs_pkg;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 64;
    localparam int CRC_W    = 8;

    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAIR    = 2'd2;

    // Reflected form of x^8+x^5+x^4+1.
    localparam logic [CRC_W-1:0] CRC_POLY = 8'h8C;

    typedef enum logic [STATUS_W-1:0] {
        ST_BIT     = 3'd0,
        ST_STARTED = 3'd1,
        ST_FOUND   = 3'd2,
        ST_CRC     = 3'd3,
        ST_NODEV   = 3'd4,
        ST_NOPRES  = 3'd5,
        ST_IGNORED = 3'd6
    } t_status;

    typedef struct packed {
        logic    dir;
        t_status status;
    } t_result;

endpackage

### hw/rtl/owrs_if.sv
// Request and response channel interfaces of the search-ROM engine.
// Depends on owrs_pkg for field widths.
interface owrs_req_if;
    logic                          valid;
    logic                          ready;
    logic [owrs_pkg::KIND_W-1:0]   kind;
    logic                          presence;
    logic                          id_bit;
    logic                          cmp_bit;

    modport source (output valid, kind, presence, id_bit, cmp_bit, input ready);
    modport sink   (input valid, kind, presence, id_bit, cmp_bit, output ready);
endinterface

interface owrs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          direction;
    logic [owrs_pkg::STATUS_W-1:0] status;
    logic [owrs_pkg::ADDR_W-1:0]   rom_address;
    logic                          last_device;

    modport source (output valid, direction, status, rom_address, last_device,
                    input ready);
    modport sink   (input valid, direction, status, rom_address, last_device,
                    output ready);
endinterface

### hw/rtl/owrs_step.sv
// Combinational decision logic for one search request: branch choice, ROM bit,
// CRC update and pass bookkeeping. Depends on owrs_pkg.
module owrs_step #(
    parameter int ROM_BITS = 64,
    parameter int BP_W     = $clog2(ROM_BITS),
    parameter int POS_W    = $clog2(ROM_BITS + 1)
) (
    input  logic [owrs_pkg::KIND_W-1:0] i_kind,
    input  logic                        i_presence,
    input  logic                        i_id_bit,
    input  logic                        i_cmp_bit,
    input  logic [ROM_BITS-1:0]         i_rom,
    input  logic [POS_W-1:0]            i_last_disc,
    input  logic [POS_W-1:0]            i_recent_zero,
    input  logic                        i_done,
    input  logic                        i_active,
    input  logic [BP_W-1:0]             i_bit_pos,
    input  logic [owrs_pkg::CRC_W-1:0]  i_crc,
    output logic [ROM_BITS-1:0]         o_rom,
    output logic [POS_W-1:0]            o_last_disc,
    output logic [POS_W-1:0]            o_recent_zero,
    output logic                        o_done,
    output logic                        o_active,
    output logic [BP_W-1:0]             o_bit_pos,
    output logic [owrs_pkg::CRC_W-1:0]  o_crc,
    output owrs_pkg::t_result           o_result
);
    import owrs_pkg::*;

    logic [POS_W-1:0] pos;
    logic             dir;
    logic [CRC_W-1:0] crc_new;
    logic [POS_W-1:0] zero_new;

    always_comb begin
        pos = POS_W'(i_bit_pos) + POS_W'(1);
        if (i_id_bit != i_cmp_bit) begin
            dir = i_id_bit;
        end else if (pos < i_last_disc) begin
            dir = i_rom[i_bit_pos];
        end else begin
            dir = (pos == i_last_disc);
        end
        zero_new = (i_id_bit == i_cmp_bit && !dir) ? pos : i_recent_zero;
        crc_new  = {1'b0, i_crc[CRC_W-1:1]} ^ ((i_crc[0] ^ dir) ? CRC_POLY : '0);
    end

    always_comb begin
        o_rom           = i_rom;
        o_last_disc     = i_last_disc;
        o_recent_zero   = i_recent_zero;
        o_done          = i_done;
        o_active        = i_active;
        o_bit_pos       = i_bit_pos;
        o_crc           = i_crc;
        o_result.dir    = 1'b0;
        o_result.status = ST_IGNORED;
        case (i_kind)
            KIND_RESTART: begin
                o_last_disc   = '0;
                o_done        = 1'b0;
                o_active      = 1'b0;
                o_recent_zero = '0;
                o_bit_pos     = '0;
                o_crc         = '0;
            end
            KIND_BEGIN: begin
                if (!i_presence || i_done) begin
                    o_last_disc     = '0;
                    o_done          = 1'b0;
                    o_active        = 1'b0;
                    o_result.status = i_presence ? ST_NODEV : ST_NOPRES;
                end else begin
                    o_active        = 1'b1;
                    o_bit_pos       = '0;
                    o_crc           = '0;
                    o_recent_zero   = '0;
                    o_result.status = ST_STARTED;
                end
            end
            KIND_PAIR: begin
                if (i_active) begin
                    if (i_id_bit && i_cmp_bit) begin
                        o_last_disc     = '0;
                        o_done          = 1'b0;
                        o_active        = 1'b0;
                        o_result.status = ST_NODEV;
                    end else begin
                        o_rom[i_bit_pos] = dir;
                        o_recent_zero    = zero_new;
                        o_crc            = crc_new;
                        o_result.dir     = dir;
                        o_result.status  = ST_BIT;
                        if (pos == POS_W'(ROM_BITS)) begin
                            o_active  = 1'b0;
                            o_bit_pos = '0;
                            if (crc_new == '0) begin
                                o_last_disc     = zero_new;
                                o_done          = (zero_new == '0);
                                o_result.status = ST_FOUND;
                            end else begin
                                o_last_disc     = '0;
                                o_done          = 1'b0;
                                o_result.status = ST_CRC;
                            end
                        end else begin
                            o_bit_pos = pos[BP_W-1:0];
                        end
                    end
                end
            end
            default: begin
                o_result.status = ST_IGNORED;
            end
        endcase
    end

endmodule

### hw/rtl/one_wire_rom_search_engine_core.sv
// Top level of the 1-Wire search-ROM decision engine: request register,
// search state, response register. Depends on owrs_pkg, owrs_if, owrs_step.
//
//   Channel   Dir  Payload                                    Handshake
//   i_req     in   kind, presence, id_bit, cmp_bit            valid/ready
//   o_rsp     out  direction, status, rom_address, last_dev   valid/ready
//
// Every request yields exactly one response: the request register holds it, and
// the response register takes the result when the response side does not stall. One
// request is accepted per cycle while the response side does not stall; the limit is the
// combinational decision step between the two registers.
// Synchronous active-low reset clears the search state and the ROM image.
// A stalled response holds the pipeline; the request register still takes one
// request while the response waits.
module one_wire_rom_search_engine_core #(
    parameter int ROM_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    owrs_req_if.sink  i_req,
    owrs_rsp_if.source o_rsp
);
    import owrs_pkg::*;

    localparam int BP_W  = $clog2(ROM_BITS);
    localparam int POS_W = $clog2(ROM_BITS + 1);

    logic              r_in_valid;
    logic [KIND_W-1:0] r_kind;
    logic              r_presence;
    logic              r_id_bit;
    logic              r_cmp_bit;

    logic              r_out_valid;
    t_result           r_result;

    logic [ROM_BITS-1:0] r_rom;
    logic [POS_W-1:0]    r_last_disc;
    logic [POS_W-1:0]    r_recent_zero;
    logic                r_done;
    logic                r_active;
    logic [BP_W-1:0]     r_bit_pos;
    logic [CRC_W-1:0]    r_crc;

    logic [ROM_BITS-1:0] n_rom;
    logic [POS_W-1:0]    n_last_disc;
    logic [POS_W-1:0]    n_recent_zero;
    logic                n_done;
    logic                n_active;
    logic [BP_W-1:0]     n_bit_pos;
    logic [CRC_W-1:0]    n_crc;
    t_result             n_result;

    logic advance;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    owrs_step #(
        .ROM_BITS (ROM_BITS),
        .BP_W     (BP_W),
        .POS_W    (POS_W)
    ) u_step (
        .i_kind        (r_kind),
        .i_presence    (r_presence),
        .i_id_bit      (r_id_bit),
        .i_cmp_bit     (r_cmp_bit),
        .i_rom         (r_rom),
        .i_last_disc   (r_last_disc),
        .i_recent_zero (r_recent_zero),
        .i_done        (r_done),
        .i_active      (r_active),
        .i_bit_pos     (r_bit_pos),
        .i_crc         (r_crc),
        .o_rom         (n_rom),
        .o_last_disc   (n_last_disc),
        .o_recent_zero (n_recent_zero),
        .o_done        (n_done),
        .o_active      (n_active),
        .o_bit_pos     (n_bit_pos),
        .o_crc         (n_crc),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_kind     <= i_req.kind;
            r_presence <= i_req.presence;
            r_id_bit   <= i_req.id_bit;
            r_cmp_bit  <= i_req.cmp_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_result      <= '{dir: 1'b0, status: ST_IGNORED};
            r_rom         <= '0;
            r_last_disc   <= '0;
            r_recent_zero <= '0;
            r_done        <= 1'b0;
            r_active      <= 1'b0;
            r_bit_pos     <= '0;
            r_crc         <= '0;
        end else begin
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_result      <= n_result;
                r_rom         <= n_rom;
                r_last_disc   <= n_last_disc;
                r_recent_zero <= n_recent_zero;
                r_done        <= n_done;
                r_active      <= n_active;
                r_bit_pos     <= n_bit_pos;
                r_crc         <= n_crc;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The search state changes only together with the response register, so
    // the ROM image and the done flag double as response fields.
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.direction   = r_result.dir;
    assign o_rsp.status      = r_result.status;
    assign o_rsp.rom_address = ADDR_W'(r_rom);
    assign o_rsp.last_device = r_done;

    a_done_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_active)
        else $error("Done flag set while a pass is active.");

    a_stall_holds_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> $stable(r_rom) && $stable(r_done))
        else $error("Search state changed under a stalled response.");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.status == ST_FOUND |-> r_done == (r_last_disc == '0))
        else $error("Done flag disagrees with last discrepancy after a find.");

    a_dir_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.dir |->
            (r_result.status == ST_BIT || r_result.status == ST_FOUND ||
             r_result.status == ST_CRC))
        else $error("Direction bit set on a response that took no bit.");

endmodule
